// ===== rtl/core/oel_pkg.sv =====
`default_nettype none
package oel_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int ENTRY_BITS_DEF = 32;

  localparam int OPC_W   = 4;
  localparam int IDX_W   = 7;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  localparam logic [OPC_W-1:0] OP_APPEND  = 4'd0;
  localparam logic [OPC_W-1:0] OP_INSERT  = 4'd1;
  localparam logic [OPC_W-1:0] OP_SET     = 4'd2;
  localparam logic [OPC_W-1:0] OP_REM_IDX = 4'd3;
  localparam logic [OPC_W-1:0] OP_REM_VAL = 4'd4;
  localparam logic [OPC_W-1:0] OP_FIND    = 4'd5;
  localparam logic [OPC_W-1:0] OP_READ    = 4'd6;
  localparam logic [OPC_W-1:0] OP_SWAP    = 4'd7;
  localparam logic [OPC_W-1:0] OP_MOVE    = 4'd8;
  localparam logic [OPC_W-1:0] OP_BSWAP   = 4'd9;
  localparam logic [OPC_W-1:0] OP_CLEAR   = 4'd10;

  // segments of a block rearrangement
  localparam int NSEG = 5;

endpackage
`default_nettype wire

// ===== rtl/core/oel_if.sv =====
`default_nettype none
interface oel_req_if import oel_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OPC_W-1:0]   opcode;
  logic [IDX_W-1:0]   first_index;
  logic [IDX_W-1:0]   second_index;
  logic [IDX_W-1:0]   third_index;
  logic [IDX_W-1:0]   fourth_index;
  logic [VAL_W-1:0]   entry_value;

  modport source (output valid, opcode, first_index, second_index, third_index,
                  fourth_index, entry_value, input ready);
  modport sink (input valid, opcode, first_index, second_index, third_index,
                fourth_index, entry_value, output ready);
endinterface

interface oel_rsp_if import oel_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic               found;
  logic [POS_W-1:0]   found_position;
  logic [VAL_W-1:0]   read_word;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, ok, found, found_position, read_word, entry_count,
                  input ready);
  modport sink (input valid, ok, found, found_position, read_word, entry_count,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/oel_ram.sv =====
`default_nettype none
module oel_ram import oel_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = ENTRY_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/ordered_entry_list_engine.sv =====
`default_nettype none
// Channel  Dir  Payload
// req      in   opcode, first_index..fourth_index, entry_value
// rsp      out  ok, found, found_position, read_word, entry_count
//
// One request at a time; req.ready is high only while the sequencer is idle.
// Set and clear act in the idle state; read and swap step through their own states.
// Insert, remove and search walk the store through one read port: a read state, then a
// write or compare state, per entry. Move and block swap gather into scratch, copy back.
// The result sits in an output register; a new request is taken while it waits.
// Synchronous reset empties the list; store contents are not cleared.
module ordered_entry_list_engine import oel_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int ENTRY_BITS = ENTRY_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  oel_req_if.sink  req,
  oel_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam int SLW = $clog2(NSEG + 1);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_INS_RD   = 5'd1;
  localparam logic [4:0] S_INS_WR   = 5'd2;
  localparam logic [4:0] S_DEL_RD   = 5'd3;
  localparam logic [4:0] S_DEL_WR   = 5'd4;
  localparam logic [4:0] S_SRCH_RD  = 5'd5;
  localparam logic [4:0] S_SRCH_CHK = 5'd6;
  localparam logic [4:0] S_READ     = 5'd7;
  localparam logic [4:0] S_READ_WT  = 5'd8;
  localparam logic [4:0] S_SWP_A    = 5'd9;
  localparam logic [4:0] S_SWP_B    = 5'd10;
  localparam logic [4:0] S_SWP_WA   = 5'd11;
  localparam logic [4:0] S_SWP_WB   = 5'd12;
  localparam logic [4:0] S_GTH_RD   = 5'd13;
  localparam logic [4:0] S_GTH_WR   = 5'd14;
  localparam logic [4:0] S_CMT_RD   = 5'd15;
  localparam logic [4:0] S_CMT_WR   = 5'd16;
  localparam logic [4:0] S_DONE     = 5'd17;

  logic [4:0]            state;
  logic [CW-1:0]         cnt;
  logic [XW-1:0]         k;
  logic [XW-1:0]         p;
  logic [XW-1:0]         a_r;
  logic [XW-1:0]         b_r;
  logic [OPC_W-1:0]      op_r;
  logic [ENTRY_BITS-1:0] v_r;
  logic [ENTRY_BITS-1:0] ta;
  logic                  ok_r;
  logic                  fnd_r;
  logic [POS_W-1:0]      pos_r;
  logic [ENTRY_BITS-1:0] rd_r;
  logic [XW-1:0]         seg_lo [NSEG];
  logic [XW-1:0]         seg_hi [NSEG];
  logic [SLW-1:0]        seg_left;

  logic                  out_valid;
  logic                  out_ok;
  logic                  out_found;
  logic [POS_W-1:0]      out_pos;
  logic [VAL_W-1:0]      out_word;
  logic [COUNT_W-1:0]    out_count;

  // request decode
  logic                  accept;
  logic [XW-1:0]         ia, ib, ic, id, nx, cs, ins_pos;
  logic [XW-1:0]         a2, b2, c2, d2;
  logic [ENTRY_BITS-1:0] vin;
  logic                  mv_ok, mv_fwd, mv_back, bs_ok;
  logic [XW-1:0]         seg_lo_in [NSEG];
  logic [XW-1:0]         seg_hi_in [NSEG];
  logic [XW-1:0]         k_m1, k_p1;

  // store ports
  logic                  m_we;
  logic [XW-1:0]         m_waddr, m_raddr;
  logic [ENTRY_BITS-1:0] m_wdata, m_rdata;
  logic                  s_we;
  logic [ENTRY_BITS-1:0] s_rdata;

  assign accept  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign ia  = XW'(req.first_index);
  assign ib  = XW'(req.second_index);
  assign ic  = XW'(req.third_index);
  assign id  = XW'(req.fourth_index);
  assign nx  = XW'(cnt);
  assign vin = ENTRY_BITS'(req.entry_value);
  assign k_m1 = k - 1'b1;
  assign k_p1 = k + 1'b1;
  assign ins_pos = (req.opcode == OP_APPEND) ? nx : ia;

  always_comb begin
    cs = (ic > nx) ? nx : ic;
    a2 = (ia > ic) ? ic : ia;
    b2 = (ia > ic) ? id : ib;
    c2 = (ia > ic) ? ia : ic;
    d2 = (ia > ic) ? ib : id;
    mv_ok   = (ia < nx) && (ib < nx) && (ia <= ib);
    mv_fwd  = cs > ib;
    mv_back = cs < ia;
    bs_ok   = (a2 <= b2) && (c2 <= d2) && (d2 < nx) && (b2 < c2);
    if (req.opcode == OP_BSWAP) begin
      seg_lo_in[0] = '0;        seg_hi_in[0] = a2;
      seg_lo_in[1] = c2;        seg_hi_in[1] = d2 + 1'b1;
      seg_lo_in[2] = b2 + 1'b1; seg_hi_in[2] = c2;
      seg_lo_in[3] = a2;        seg_hi_in[3] = b2 + 1'b1;
      seg_lo_in[4] = d2 + 1'b1; seg_hi_in[4] = nx;
    end else if (mv_back) begin
      seg_lo_in[0] = '0;        seg_hi_in[0] = cs;
      seg_lo_in[1] = ia;        seg_hi_in[1] = ib + 1'b1;
      seg_lo_in[2] = cs;        seg_hi_in[2] = ia;
      seg_lo_in[3] = ib + 1'b1; seg_hi_in[3] = nx;
      seg_lo_in[4] = nx;        seg_hi_in[4] = nx;
    end else begin
      seg_lo_in[0] = '0;        seg_hi_in[0] = ia;
      seg_lo_in[1] = ib + 1'b1; seg_hi_in[1] = cs;
      seg_lo_in[2] = ia;        seg_hi_in[2] = ib + 1'b1;
      seg_lo_in[3] = cs;        seg_hi_in[3] = nx;
      seg_lo_in[4] = nx;        seg_hi_in[4] = nx;
    end
  end

  always_comb begin
    m_we    = 1'b0;
    m_waddr = k;
    m_wdata = m_rdata;
    m_raddr = k;
    case (state)
      S_IDLE: begin
        if (accept && req.opcode == OP_SET && ia < nx) begin
          m_we    = 1'b1;
          m_waddr = ia;
          m_wdata = vin;
        end
      end
      S_INS_RD: begin
        m_raddr = k_m1;
        if (!(k > a_r)) begin
          m_we    = 1'b1;
          m_waddr = a_r;
          m_wdata = v_r;
        end
      end
      S_INS_WR, S_DEL_WR: m_we = 1'b1;
      S_DEL_RD:           m_raddr = k_p1;
      S_READ, S_SWP_A:    m_raddr = a_r;
      S_SWP_B:            m_raddr = b_r;
      S_SWP_WA: begin
        m_we    = 1'b1;
        m_waddr = a_r;
      end
      S_SWP_WB: begin
        m_we    = 1'b1;
        m_waddr = b_r;
        m_wdata = ta;
      end
      S_CMT_WR: begin
        m_we    = 1'b1;
        m_waddr = p;
        m_wdata = s_rdata;
      end
      default: ;
    endcase
  end

  assign s_we = (state == S_GTH_WR);

  oel_ram #(.DEPTH(DEPTH), .WIDTH(ENTRY_BITS)) u_store (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr[AW-1:0]),
    .wdata (m_wdata),
    .raddr (m_raddr[AW-1:0]),
    .rdata (m_rdata)
  );

  oel_ram #(.DEPTH(DEPTH), .WIDTH(ENTRY_BITS)) u_scratch (
    .clk   (clk),
    .we    (s_we),
    .waddr (p[AW-1:0]),
    .wdata (m_rdata),
    .raddr (p[AW-1:0]),
    .rdata (s_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // in S_DONE the output register is reloaded or held below
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_r  <= req.opcode;
            v_r   <= vin;
            a_r   <= ia;
            b_r   <= ib;
            ok_r  <= 1'b0;
            fnd_r <= 1'b0;
            pos_r <= '0;
            rd_r  <= '0;
            state <= S_DONE;
            case (req.opcode)
              OP_APPEND, OP_INSERT: begin
                if (ins_pos <= nx && nx < XW'(DEPTH)) begin
                  a_r   <= ins_pos;
                  k     <= nx;
                  ok_r  <= 1'b1;
                  state <= S_INS_RD;
                end
              end
              OP_SET: ok_r <= (ia < nx);
              OP_REM_IDX: begin
                if (ia < nx) begin
                  k     <= ia;
                  ok_r  <= 1'b1;
                  state <= S_DEL_RD;
                end
              end
              OP_REM_VAL, OP_FIND: begin
                k     <= '0;
                ok_r  <= (req.opcode == OP_FIND);
                state <= S_SRCH_RD;
              end
              OP_READ: begin
                if (ia < nx) begin
                  ok_r  <= 1'b1;
                  state <= S_READ;
                end
              end
              OP_SWAP: begin
                if (ia < nx && ib < nx) begin
                  ok_r  <= 1'b1;
                  state <= S_SWP_A;
                end
              end
              OP_MOVE, OP_BSWAP: begin
                if ((req.opcode == OP_MOVE) ? mv_ok : bs_ok) begin
                  ok_r <= 1'b1;
                  if (req.opcode == OP_BSWAP || mv_fwd || mv_back) begin
                    for (int i = 0; i < NSEG; i++) begin
                      seg_lo[i] <= seg_lo_in[i];
                      seg_hi[i] <= seg_hi_in[i];
                    end
                    seg_left <= SLW'(NSEG);
                    k        <= seg_lo_in[0];
                    p        <= '0;
                    state    <= S_GTH_RD;
                  end
                end
              end
              OP_CLEAR: begin
                cnt  <= '0;
                ok_r <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_INS_RD: begin
          if (k > a_r) begin
            state <= S_INS_WR;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_DONE;
          end
        end
        S_INS_WR: begin
          k     <= k_m1;
          state <= S_INS_RD;
        end
        S_DEL_RD: begin
          if (k_p1 < nx) begin
            state <= S_DEL_WR;
          end else begin
            cnt   <= cnt - 1'b1;
            state <= S_DONE;
          end
        end
        S_DEL_WR: begin
          k     <= k_p1;
          state <= S_DEL_RD;
        end
        S_SRCH_RD: state <= (k < nx) ? S_SRCH_CHK : S_DONE;
        S_SRCH_CHK: begin
          if (m_rdata == v_r) begin
            fnd_r <= 1'b1;
            pos_r <= k[POS_W-1:0];
            if (op_r == OP_FIND) begin
              state <= S_DONE;
            end else begin
              ok_r  <= 1'b1;
              state <= S_DEL_RD;
            end
          end else begin
            k     <= k_p1;
            state <= S_SRCH_RD;
          end
        end
        S_READ:    state <= S_READ_WT;
        S_READ_WT: begin
          rd_r  <= m_rdata;
          state <= S_DONE;
        end
        S_SWP_A:   state <= S_SWP_B;
        S_SWP_B: begin
          ta    <= m_rdata;
          state <= S_SWP_WA;
        end
        S_SWP_WA:  state <= S_SWP_WB;
        S_SWP_WB:  state <= S_DONE;
        S_GTH_RD: begin
          if (seg_left == '0) begin
            p     <= '0;
            state <= S_CMT_RD;
          end else if (k >= seg_hi[0]) begin
            // segment exhausted: shift the list down, start the next one
            for (int i = 0; i < NSEG - 1; i++) begin
              seg_lo[i] <= seg_lo[i+1];
              seg_hi[i] <= seg_hi[i+1];
            end
            k        <= seg_lo[1];
            seg_left <= seg_left - 1'b1;
          end else begin
            state <= S_GTH_WR;
          end
        end
        S_GTH_WR: begin
          p     <= p + 1'b1;
          k     <= k_p1;
          state <= S_GTH_RD;
        end
        S_CMT_RD:  state <= (p < nx) ? S_CMT_WR : S_DONE;
        S_CMT_WR: begin
          p     <= p + 1'b1;
          state <= S_CMT_RD;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_ok    <= ok_r;
            out_found <= fnd_r;
            out_pos   <= pos_r;
            out_word  <= VAL_W'(rd_r);
            out_count <= COUNT_W'(cnt);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.ok             = out_ok;
  assign rsp.found          = out_found;
  assign rsp.found_position = out_pos;
  assign rsp.read_word      = out_word;
  assign rsp.entry_count    = out_count;

endmodule
`default_nettype wire

// ===== rtl/core/oel_chk.sv =====
`default_nettype none
module oel_chk import oel_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic               ok,
  input wire logic               found,
  input wire logic [POS_W-1:0]   found_position,
  input wire logic [VAL_W-1:0]   read_word,
  input wire logic [COUNT_W-1:0] entry_count
);

  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_count) && $stable(ok))
    else $error("stalled result changed");

  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(entry_count) <= DEPTH)
    else $error("entry count above capacity");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && found |-> ok)
    else $error("match reported on a failed transaction");

  a_nomatch: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> found_position == '0 && (read_word == '0 || ok))
    else $error("stray position or read data");

endmodule

bind ordered_entry_list_engine oel_chk #(.DEPTH(DEPTH)) u_oel_chk (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .ok             (rsp.ok),
  .found          (rsp.found),
  .found_position (rsp.found_position),
  .read_word      (rsp.read_word),
  .entry_count    (rsp.entry_count)
);
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import oel_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int RANDOM_ITEMS = 660;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
    logic [IDX_W-1:0] ic;
    logic [IDX_W-1:0] id;
    logic [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic             ok;
    logic             found;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] word;
    logic [COUNT_W-1:0] count;
  } response_t;

  // directed row: request, whether the response is typed in, and that response
  typedef struct packed {
    request_t  stim;
    logic      fixed;
    response_t resp;
  } vector_t;

  logic clk;
  logic rst;
  longint cycle_count;
  int mismatch_count;
  bit stimulus_done;

  oel_req_if req ();
  oel_rsp_if rsp ();

  ordered_entry_list_engine DUT (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // predictor state
  logic [VAL_W-1:0] list_words [LIST_DEPTH];
  int unsigned list_len;
  response_t pending_responses [$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic response_t predict_list_op(request_t r);
    response_t o;
    logic [VAL_W-1:0] work [LIST_DEPTH];
    logic [VAL_W-1:0] t;
    int unsigned n, a, b, c, d, k, p;
    bit hit;
    o = '0;
    n = list_len;
    a = r.ia; b = r.ib; c = r.ic; d = r.id;
    hit = 1'b0;
    p = 0;
    case (r.opcode)
      OP_APPEND, OP_INSERT: begin
        if (r.opcode == OP_APPEND) a = n;
        if (a <= n && n < LIST_DEPTH) begin
          for (k = n; k > a; k--) list_words[k] = list_words[k-1];
          list_words[a] = r.value;
          list_len = n + 1;
          o.ok = 1'b1;
        end
      end
      OP_SET: if (a < n) begin
        list_words[a] = r.value;
        o.ok = 1'b1;
      end
      OP_REM_IDX, OP_REM_VAL, OP_FIND: begin
        if (r.opcode == OP_REM_IDX) begin
          hit = a < n;
          p = a;
        end else begin
          for (k = 0; k < n; k++)
            if (!hit && list_words[k] == r.value) begin
              hit = 1'b1;
              p = k;
            end
          o.found = hit;
          o.position = hit ? p[POS_W-1:0] : '0;
        end
        if (r.opcode == OP_FIND) o.ok = 1'b1;
        else if (hit) begin
          for (k = p; k + 1 < n; k++) list_words[k] = list_words[k+1];
          list_len = n - 1;
          o.ok = 1'b1;
        end
      end
      OP_READ: if (a < n) begin
        o.word = list_words[a];
        o.ok = 1'b1;
      end
      OP_SWAP: if (a < n && b < n) begin
        t = list_words[a];
        list_words[a] = list_words[b];
        list_words[b] = t;
        o.ok = 1'b1;
      end
      OP_MOVE: if (a < n && b < n && a <= b) begin
        if (c > n) c = n;
        o.ok = 1'b1;
        if (c > b) begin
          for (k = 0; k < a; k++) work[p++] = list_words[k];
          for (k = b + 1; k < c; k++) work[p++] = list_words[k];
          for (k = a; k <= b; k++) work[p++] = list_words[k];
          for (k = c; k < n; k++) work[p++] = list_words[k];
          for (k = 0; k < n; k++) list_words[k] = work[k];
        end else if (c < a) begin
          for (k = 0; k < c; k++) work[p++] = list_words[k];
          for (k = a; k <= b; k++) work[p++] = list_words[k];
          for (k = c; k < a; k++) work[p++] = list_words[k];
          for (k = b + 1; k < n; k++) work[p++] = list_words[k];
          for (k = 0; k < n; k++) list_words[k] = work[k];
        end
      end
      OP_BSWAP: begin
        if (a > c) begin
          k = a; a = c; c = k;
          k = b; b = d; d = k;
        end
        if (a <= b && c <= d && d < n && b < c) begin
          for (k = 0; k < a; k++) work[p++] = list_words[k];
          for (k = c; k <= d; k++) work[p++] = list_words[k];
          for (k = b + 1; k < c; k++) work[p++] = list_words[k];
          for (k = a; k <= b; k++) work[p++] = list_words[k];
          for (k = d + 1; k < n; k++) work[p++] = list_words[k];
          for (k = 0; k < n; k++) list_words[k] = work[k];
          o.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        list_len = 0;
        o.ok = 1'b1;
      end
      default: ;
    endcase
    o.count = list_len[COUNT_W-1:0];
    return o;
  endfunction

  function automatic response_t expect_resp(logic ok, logic fnd, int pos, logic [31:0] w,
                                           int cnt);
    response_t o;
    o.ok = ok; o.found = fnd; o.position = pos[POS_W-1:0];
    o.word = w; o.count = cnt[COUNT_W-1:0];
    return o;
  endfunction

  function automatic request_t mk(logic [OPC_W-1:0] op, int a, int b, int c, int d,
                                  logic [31:0] v);
    request_t r;
    r.opcode = op; r.ia = a[IDX_W-1:0]; r.ib = b[IDX_W-1:0];
    r.ic = c[IDX_W-1:0]; r.id = d[IDX_W-1:0]; r.value = v;
    return r;
  endfunction

  // random index, mostly in range of the current list with some slack
  function automatic int pick_index();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return $urandom_range(0, 127);
    if (list_len == 0 || r == 1) return $urandom_range(0, list_len + 2);
    return $urandom_range(0, list_len - 1);
  endfunction

  function automatic request_t random_request();
    request_t r;
    int unsigned sel, a, b, c, d;
    sel = $urandom_range(0, 99);
    r.value = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
    if (sel < 4) r.opcode = OPC_W'($urandom_range(OP_CLEAR, 15));
    else if (sel < 22) r.opcode = (list_len > 48) ? OP_REM_IDX : OP_APPEND;
    else if (sel < 34) r.opcode = OP_INSERT;
    else r.opcode = OPC_W'($urandom_range(OP_SET, OP_BSWAP));
    if (sel < 4 && r.opcode == OP_CLEAR && $urandom_range(0, 3) != 0)
      r.opcode = OP_READ;
    a = pick_index(); b = pick_index(); c = pick_index(); d = pick_index();
    if (r.opcode == OP_MOVE && a > b) begin sel = a; a = b; b = sel; end
    if (r.opcode == OP_BSWAP && $urandom_range(0, 3) != 0 && list_len >= 2) begin
      // well-formed disjoint blocks
      a = $urandom_range(0, list_len - 2);
      b = $urandom_range(a, list_len - 2);
      c = $urandom_range(b + 1, list_len - 1);
      d = $urandom_range(c, list_len - 1);
      if ($urandom_range(0, 1)) begin sel = a; a = c; c = sel; sel = b; b = d; d = sel; end
    end
    r.ia = a[IDX_W-1:0]; r.ib = b[IDX_W-1:0]; r.ic = c[IDX_W-1:0]; r.id = d[IDX_W-1:0];
    return r;
  endfunction

  task automatic send_request(request_t r);
    req.valid        <= 1'b1;
    req.opcode       <= r.opcode;
    req.first_index  <= r.ia;
    req.second_index <= r.ib;
    req.third_index  <= r.ic;
    req.fourth_index <= r.id;
    req.entry_value  <= r.value;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic sender_gap();
    int unsigned g;
    g = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    if (g != 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  vector_t directed [$];
  int burst;

  initial begin
    request_t r;
    response_t e;
    rst = 1'b1;
    req.valid <= 1'b0;
    req.opcode <= '0; req.first_index <= '0; req.second_index <= '0;
    req.third_index <= '0; req.fourth_index <= '0; req.entry_value <= '0;
    stimulus_done = 1'b0;
    list_len = 0;
    foreach (list_words[i]) list_words[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // on an empty list every index is out of range
    directed.push_back({mk(OP_READ, 0, 0, 0, 0, 0), 1'b1, expect_resp(0, 0, 0, 0, 0)});
    directed.push_back({mk(OP_REM_VAL, 0, 0, 0, 0, 5), 1'b1, expect_resp(0, 0, 0, 0, 0)});
    directed.push_back({mk(OP_FIND, 0, 0, 0, 0, 5), 1'b1, expect_resp(1, 0, 0, 0, 0)});
    directed.push_back({mk(OP_INSERT, 1, 0, 0, 0, 7), 1'b1, expect_resp(0, 0, 0, 0, 0)});
    directed.push_back({mk(OP_APPEND, 0, 0, 0, 0, 32'hFFFF_FFFF), 1'b1,
                        expect_resp(1, 0, 0, 0, 1)});
    directed.push_back({mk(OP_INSERT, 1, 0, 0, 0, 0), 1'b1, expect_resp(1, 0, 0, 0, 2)});
    directed.push_back({mk(OP_INSERT, 0, 0, 0, 0, 32'h5555_AAAA), 1'b0, response_t'(0)});
    directed.push_back({mk(OP_READ, 0, 0, 0, 0, 0), 1'b1,
                        expect_resp(1, 0, 0, 32'h5555_AAAA, 3)});
    directed.push_back({mk(OP_SET, 127, 0, 0, 0, 1), 1'b1, expect_resp(0, 0, 0, 0, 3)});
    directed.push_back({mk(OP_SET, 2, 0, 0, 0, 32'hAAAA_5555), 1'b0, response_t'(0)});
    directed.push_back({mk(OP_SWAP, 0, 3, 0, 0, 0), 1'b1, expect_resp(0, 0, 0, 0, 3)});
    directed.push_back({mk(OP_SWAP, 0, 2, 0, 0, 0), 1'b0, response_t'(0)});
    directed.push_back({mk(OP_FIND, 0, 0, 0, 0, 32'hFFFF_FFFF), 1'b0, response_t'(0)});
    directed.push_back({mk(OP_MOVE, 0, 0, 127, 0, 0), 1'b0, response_t'(0)});
    directed.push_back({mk(OP_MOVE, 1, 2, 1, 0, 0), 1'b0, response_t'(0)});
    directed.push_back({mk(OP_MOVE, 2, 1, 0, 0, 0), 1'b1, expect_resp(0, 0, 0, 0, 3)});
    directed.push_back({mk(OP_BSWAP, 2, 2, 0, 0, 0), 1'b0, response_t'(0)});
    directed.push_back({mk(OP_BSWAP, 0, 1, 1, 2, 0), 1'b1, expect_resp(0, 0, 0, 0, 3)});
    directed.push_back({mk(OP_REM_VAL, 0, 0, 0, 0, 0), 1'b0, response_t'(0)});
    directed.push_back({mk(OP_REM_IDX, 5, 0, 0, 0, 0), 1'b1, expect_resp(0, 0, 0, 0, 3)});
    directed.push_back({mk(OP_REM_IDX, 1, 0, 0, 0, 0), 1'b0, response_t'(0)});
    directed.push_back({mk(4'd15, 0, 0, 0, 0, 0), 1'b1, expect_resp(0, 0, 0, 0, 2)});
    directed.push_back({mk(OP_CLEAR, 0, 0, 0, 0, 0), 1'b1, expect_resp(1, 0, 0, 0, 0)});

    foreach (directed[i]) begin
      r = directed[i].stim;
      e = predict_list_op(r);
      pending_responses.push_back(directed[i].fixed ? directed[i].resp : e);
      send_request(r);
    end

    // fill to capacity, then check overflow
    repeat (LIST_DEPTH) begin
      r = mk(OP_APPEND, 0, 0, 0, 0, $urandom);
      pending_responses.push_back(predict_list_op(r));
      send_request(r);
    end
    r = mk(OP_INSERT, 0, 0, 0, 0, 1);
    pending_responses.push_back(predict_list_op(r));
    send_request(r);
    r = mk(OP_BSWAP, 63, 63, 0, 0, 0);
    pending_responses.push_back(predict_list_op(r));
    send_request(r);

    burst = 0;
    repeat (RANDOM_ITEMS) begin
      if (burst == 0) begin
        sender_gap();
        burst = $urandom_range(1, 12);
      end
      burst--;
      r = random_request();
      pending_responses.push_back(predict_list_op(r));
      send_request(r);
    end
    req.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // receiver stall pattern: long open stretches alternating with choppy ones
  initial begin
    int unsigned phase;
    rsp.ready <= 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (phase[8]) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    response_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.ok, rsp.found, rsp.found_position, rsp.read_word, rsp.entry_count};
      if (pending_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected response transaction %p", got);
      end else begin
        want = pending_responses.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected ok=%0b found=%0b pos=%0d word=%h count=%0d,",
                      " got ok=%0b found=%0b pos=%0d word=%h count=%0d"},
                     want.ok, want.found, want.position, want.word, want.count,
                     got.ok, got.found, got.position, got.word, got.count);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    mismatch_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    wait (stimulus_done);
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/oel_pkg.sv
rtl/core/oel_if.sv
rtl/core/oel_ram.sv
rtl/core/ordered_entry_list_engine.sv
rtl/core/oel_chk.sv
test/tb_top.sv
